/* hdl/mdvt_pkg.sv */
// ----------------------------------------------------------------------------
// mdvt_pkg
// shared constants, state encoding and controller/datapath interface types
// ----------------------------------------------------------------------------
package mdvt_pkg;

  // table of configurations
  localparam int unsigned CONF_ENTRIES  = 65536;
  localparam int unsigned CONF_AW       = $clog2(CONF_ENTRIES);
  localparam int unsigned CONF_W        = 16;

  // depth values and per-depth counters
  localparam int unsigned MAX_DEPTH     = 255;
  localparam int unsigned DEPTH_W       = 8;
  localparam int unsigned COUNT_ENTRIES = MAX_DEPTH + 1;
  localparam int unsigned COUNT_AW      = $clog2(COUNT_ENTRIES);
  localparam int unsigned COUNT_W       = 17;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // clearing sweep covers both stores
  localparam int unsigned CLEAR_LEN =
    (CONF_ENTRIES > COUNT_ENTRIES) ? CONF_ENTRIES : COUNT_ENTRIES;
  localparam int unsigned CLEAR_W   = $clog2(CLEAR_LEN);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_WRITE_OLD
  } state_t;

  typedef struct packed {
    logic clear;      // sweep one address of both stores (counters only below COUNT_ENTRIES)
    logic load;       // capture request, read table and count of new depth
    logic fetch_old;  // capture old depth, read its count
    logic update;     // decide, write table and new count, drive result
    logic write_old;  // write back decremented count of old depth
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last; // sweep is on its last address
    logic take;       // request will be stored
    logic old_seen;   // old depth has a counter to decrement
  } dp_status_t;

endpackage

/* hdl/mdvt_ram.sv */
// ----------------------------------------------------------------------------
// mdvt_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module mdvt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/mdvt_ctrl.sv */
// ----------------------------------------------------------------------------
// mdvt_ctrl
// sequencer: clearing sweep, then read / decide / write per request
// ----------------------------------------------------------------------------
module mdvt_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  output mdvt_pkg::dp_cmd_t    cmd,
  input  mdvt_pkg::dp_status_t status
);

  import mdvt_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.fetch_old = 1'b1;
        state_next    = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        if (status.take && status.old_seen) begin
          state_next = ST_WRITE_OLD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_WRITE_OLD: begin
        cmd.write_old = 1'b1;
        state_next    = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

/* hdl/mdvt_dp.sv */
// ----------------------------------------------------------------------------
// mdvt_dp
// depth table, per-depth counters, request registers and result registers
// ----------------------------------------------------------------------------
module mdvt_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  mdvt_pkg::dp_cmd_t             cmd,
  output mdvt_pkg::dp_status_t          status,
  input  logic [mdvt_pkg::CONF_W-1:0]   conf_number,
  input  logic [mdvt_pkg::DEPTH_W-1:0]  new_depth,
  output logic                          done,
  output logic                          accepted,
  output logic [mdvt_pkg::DEPTH_W-1:0]  previous_depth,
  output logic [mdvt_pkg::COUNT_W-1:0]  new_depth_count
);

  import mdvt_pkg::*;

  // request and fetched state
  logic [CONF_AW-1:0] conf;
  logic [DEPTH_W-1:0] nd;
  logic [DEPTH_W-1:0] old;
  logic [COUNT_W-1:0] cnt_nd;
  logic [COUNT_W-1:0] cnt_old;
  logic [CLEAR_W-1:0] clr_addr;

  // ram ports
  logic               tbl_we;
  logic [CONF_AW-1:0] tbl_waddr;
  logic [DEPTH_W-1:0] tbl_wdata;
  logic [CONF_AW-1:0] tbl_raddr;
  logic [DEPTH_W-1:0] tbl_rdata;
  logic                cnt_we;
  logic [COUNT_AW-1:0] cnt_waddr;
  logic [COUNT_W-1:0]  cnt_wdata;
  logic [COUNT_AW-1:0] cnt_raddr;
  logic [COUNT_W-1:0]  cnt_rdata;

  // decision
  logic               nd_ok;
  logic               take;
  logic               old_seen;
  logic [COUNT_W-1:0] cnt_inc;
  logic [COUNT_W-1:0] cnt_dec;
  logic               tbl_clr_ok;
  logic               cnt_clr_ok;

  assign nd_ok    = (nd != '0) && ({1'b0, nd} <= (DEPTH_W+1)'(MAX_DEPTH));
  assign take     = nd_ok && ((old == '0) || (old > nd));
  assign old_seen = (old != '0) && ({1'b0, old} <= (DEPTH_W+1)'(MAX_DEPTH));
  assign cnt_inc  = (cnt_nd == COUNT_MAX) ? cnt_nd : cnt_nd + 1'b1;
  assign cnt_dec  = (cnt_old == '0) ? cnt_old : cnt_old - 1'b1;

  assign tbl_clr_ok = ({1'b0, clr_addr} < (CLEAR_W+1)'(CONF_ENTRIES));
  assign cnt_clr_ok = ({1'b0, clr_addr} < (CLEAR_W+1)'(COUNT_ENTRIES));

  assign status.clear_last = (clr_addr == CLEAR_W'(CLEAR_LEN - 1));
  assign status.take       = take;
  assign status.old_seen   = old_seen;

  // table port muxing
  assign tbl_raddr = cmd.load ? CONF_AW'(conf_number) : conf;
  assign tbl_we    = (cmd.clear && tbl_clr_ok) || (cmd.update && take);
  assign tbl_waddr = cmd.clear ? CONF_AW'(clr_addr) : conf;
  assign tbl_wdata = cmd.clear ? '0 : nd;

  // counter port muxing; old and new depth differ whenever both are written
  always_comb begin
    if (cmd.load) begin
      cnt_raddr = COUNT_AW'(new_depth);
    end else if (cmd.fetch_old) begin
      cnt_raddr = COUNT_AW'(tbl_rdata);
    end else begin
      cnt_raddr = COUNT_AW'(old);
    end
  end

  assign cnt_we    = (cmd.clear && cnt_clr_ok) || (cmd.update && take) || cmd.write_old;
  always_comb begin
    if (cmd.clear) begin
      cnt_waddr = COUNT_AW'(clr_addr);
      cnt_wdata = '0;
    end else if (cmd.write_old) begin
      cnt_waddr = COUNT_AW'(old);
      cnt_wdata = cnt_dec;
    end else begin
      cnt_waddr = COUNT_AW'(nd);
      cnt_wdata = cnt_inc;
    end
  end

  mdvt_ram #(
    .WIDTH (DEPTH_W),
    .DEPTH (CONF_ENTRIES)
  ) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  mdvt_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (COUNT_ENTRIES)
  ) u_cnt (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  // clearing sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // request capture and fetched values
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      conf <= CONF_AW'(conf_number);
      nd   <= new_depth;
    end
    if (cmd.fetch_old) begin
      old    <= tbl_rdata;
      cnt_nd <= cnt_rdata;
    end
    if (cmd.update) begin
      cnt_old <= cnt_rdata;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.update;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      accepted       <= take;
      previous_depth <= old;
      if (!nd_ok) begin
        new_depth_count <= '0;
      end else if (take) begin
        new_depth_count <= cnt_inc;
      end else begin
        new_depth_count <= cnt_nd;
      end
    end
  end

endmodule

/* hdl/min_depth_visit_table_core.sv */
// ----------------------------------------------------------------------------
// min_depth_visit_table_core
// smallest search depth per configuration, with per-depth population counts
// ----------------------------------------------------------------------------
//
// channel   handshake             payload
// -------   -------------------   -----------------------------------------
// request   start / busy          conf_number[15:0], new_depth[7:0]
// result    done (one-cycle)      accepted, previous_depth[7:0],
//                                 new_depth_count[16:0]
//
// a request word is taken on a clock edge with start high and busy low
// the result word shows on the cycle after the decision, for one cycle, with
// done high; the receiver cannot stall it
// a request that replaces a seen depth takes an extra write-old state (counter
// write-back on the single counter write port) before busy drops again
// after reset busy stays high while all 65536 table addresses and the 256
// counter addresses are swept to zero, one address a cycle
//
module min_depth_visit_table_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [mdvt_pkg::CONF_W-1:0]   conf_number,
  input  logic [mdvt_pkg::DEPTH_W-1:0]  new_depth,
  output logic                          done,
  output logic                          accepted,
  output logic [mdvt_pkg::DEPTH_W-1:0]  previous_depth,
  output logic [mdvt_pkg::COUNT_W-1:0]  new_depth_count
);

  import mdvt_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer: clear sweep, then load -> fetch old -> update -> write old (when a seen depth is replaced)
  mdvt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  // datapath: table ram, counter ram, decision and result registers
  mdvt_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .conf_number     (conf_number),
    .new_depth       (new_depth),
    .done            (done),
    .accepted        (accepted),
    .previous_depth  (previous_depth),
    .new_depth_count (new_depth_count)
  );

endmodule
